// ===== rtl/ffac_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ffac_pkg;

    // cache geometry
    localparam int ENTRIES = 16;
    localparam int DATA_W  = 32;

    // fixed field widths
    localparam int ADDR_W  = 32;
    localparam int FIELD_W = 32;
    localparam int OP_W    = 2;
    localparam int CFG_W   = 5;

    // derived widths
    localparam int STORE_W = (DATA_W < FIELD_W) ? DATA_W : FIELD_W;
    localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W   = $clog2(ENTRIES + 1);

    // request queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_READ  = 2'd0,
        OP_PUT   = 2'd1,
        OP_WRITE = 2'd2
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [ADDR_W-1:0]  addr;
        logic [STORE_W-1:0] data;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic [FIELD_W-1:0] read_data;
        logic               evicted;
        logic [ADDR_W-1:0]  evict_addr;
        logic [FIELD_W-1:0] evict_data;
        logic               evict_dirty;
    } t_rsp;

    typedef struct packed {
        logic [OCC_W-1:0]  occupancy;
        logic [SLOT_W-1:0] oldest;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/ffac_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffac_front (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  wire  [ffac_pkg::OP_W-1:0]    i_op,
    input  wire  [ffac_pkg::ADDR_W-1:0]  i_addr,
    input  wire  [ffac_pkg::FIELD_W-1:0] i_data,
    output logic                   o_valid,
    output ffac_pkg::t_req         o_req,
    input  wire                    i_full
);
    import ffac_pkg::*;

    logic r_vld;
    logic n_vld;
    t_req r_req;
    t_op  op_dec;
    logic push;
    logic take;

    // fold the unused code into a read
    always_comb begin
        unique case (i_op)
            OP_PUT:   op_dec = OP_PUT;
            OP_WRITE: op_dec = OP_WRITE;
            default:  op_dec = OP_READ;
        endcase
    end

    assign push    = r_vld && !i_full;
    assign o_ready = !r_vld || !i_full;
    assign take    = i_valid && o_ready;
    assign n_vld   = take || (r_vld && !push);

    // hold the classified request until the queue has room
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        if (take) begin
            r_req.op   <= op_dec;
            r_req.addr <= i_addr;
            r_req.data <= i_data[STORE_W-1:0];
        end
    end

    assign o_valid = r_vld;
    assign o_req   = r_req;

endmodule

`default_nettype wire

// ===== rtl/ffac_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffac_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  ffac_pkg::t_req  i_req,
    output logic            o_full,
    output logic            o_valid,
    output ffac_pkg::t_req  o_req,
    input  wire             i_pop
);
    import ffac_pkg::*;

    t_req              r_buf [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_req   = r_buf[r_rd];

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (do_push) begin
            r_buf[r_wr] <= i_req;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ffac_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffac_back (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire  [ffac_pkg::CFG_W-1:0] i_capacity,
    input  wire                       i_valid,
    input  ffac_pkg::t_req            i_req,
    output logic                      o_pop,
    output logic                      o_valid,
    output ffac_pkg::t_rsp            o_rsp,
    input  wire                       i_ready,
    output ffac_pkg::t_stat           o_stat
);
    import ffac_pkg::*;

    // entry storage
    logic [ADDR_W-1:0]  r_addr  [ENTRIES];
    logic [STORE_W-1:0] r_data  [ENTRIES];
    logic               r_dirty [ENTRIES];
    logic [OCC_W-1:0]   r_occ;
    logic [SLOT_W-1:0]  r_oldest;
    logic               r_out_vld;
    t_rsp               r_rsp;

    logic [OCC_W-1:0]   eff_cap;
    logic [ENTRIES-1:0] match;
    logic               hit;
    logic [SLOT_W-1:0]  hit_slot;
    logic [SLOT_W-1:0]  ev_slot;
    logic [SLOT_W-1:0]  ev_next;
    logic [OCC_W-1:0]   ev_inc;
    logic               full;
    logic               is_fill;
    logic               evict;
    logic [SLOT_W-1:0]  wr_slot;
    logic [SLOT_W-1:0]  rd_slot;
    logic               wr_en;
    logic               take;
    t_rsp               n_rsp;

    // clamp capacity to the legal range
    always_comb begin
        if (i_capacity == '0) begin
            eff_cap = OCC_W'(1);
        end else if (32'(i_capacity) > ENTRIES) begin
            eff_cap = OCC_W'(ENTRIES);
        end else begin
            eff_cap = OCC_W'(i_capacity);
        end
    end

    // compare against every occupied slot
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = (OCC_W'(i) < r_occ) && (r_addr[i] == i_req.addr);
        end
    end

    // lowest matching slot wins
    always_comb begin
        hit_slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_slot = SLOT_W'(i);
            end
        end
    end

    assign hit = |match;

    // victim selection, round-robin over occupied slots
    assign ev_slot = (OCC_W'(r_oldest) >= r_occ) ? '0 : r_oldest;
    assign ev_inc  = OCC_W'(ev_slot) + 1'b1;
    assign ev_next = (ev_inc >= r_occ) ? '0 : SLOT_W'(ev_inc);

    assign full    = (r_occ >= eff_cap);
    assign take    = i_valid && (!r_out_vld || i_ready);
    assign wr_en   = take && (i_req.op != OP_READ);
    assign is_fill = wr_en && !hit;
    assign evict   = is_fill && full;
    assign wr_slot = hit ? hit_slot : (full ? ev_slot : SLOT_W'(r_occ));
    assign rd_slot = hit ? hit_slot : ev_slot;

    // build the result for this request
    always_comb begin
        n_rsp             = '0;
        n_rsp.hit         = hit;
        if (i_req.op == OP_READ && hit) begin
            n_rsp.read_data = FIELD_W'(r_data[rd_slot]);
        end
        if (evict) begin
            n_rsp.evicted     = 1'b1;
            n_rsp.evict_addr  = r_addr[rd_slot];
            n_rsp.evict_data  = FIELD_W'(r_data[rd_slot]);
            n_rsp.evict_dirty = r_dirty[rd_slot];
        end
    end

    // update state and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ     <= '0;
            r_oldest  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (take) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
            if (is_fill && !full) begin
                r_occ <= r_occ + 1'b1;
            end
            if (evict) begin
                r_oldest <= ev_next;
            end
        end
        if (take) begin
            r_rsp <= n_rsp;
        end
        if (wr_en) begin
            r_addr[wr_slot]  <= i_req.addr;
            r_data[wr_slot]  <= i_req.data;
            r_dirty[wr_slot] <= (i_req.op == OP_WRITE);
        end
    end

    assign o_pop            = take;
    assign o_valid          = r_out_vld;
    assign o_rsp            = r_rsp;
    assign o_stat.occupancy = r_occ;
    assign o_stat.oldest    = r_oldest;

endmodule

`default_nettype wire

// ===== rtl/fifo_fully_assoc_cache.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Fully associative cache of up to 16 entries with FIFO replacement. Each
// request carries op (read, put or write), an address and a data word, and
// yields exactly one result: hit, read data, and the address, data and dirty
// mark of any entry evicted by a fill. A sustained rate of one request per
// cycle is reached while the result stream is not stalled; every entry is
// compared in parallel and the entry state is updated in the same cycle,
// which is the path that sets this rate. The input register that classifies
// the op captures a request at acceptance, the request then enters the
// two-entry request queue, and the lookup stage loads the output register
// from the queue; a full queue or a stalled result can hold it. The capacity
// register (offset 0) limits how many entries fill before eviction starts;
// write it only while no request is in flight.
module fifo_fully_assoc_cache (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // request stream
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [63:0]  s_axis_tdata,  // addr[31:0], data[63:32]
    input  wire  [1:0]   s_axis_tuser,  // op[1:0]
    // result stream
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [103:0] m_axis_tdata,  // read_data[31:0], evict_addr[63:32],
                                        // evict_data[95:64], evict_dirty[96]
    output logic [1:0]   m_axis_tuser,  // hit[0], evicted[1]
    // configuration
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [2:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import ffac_pkg::*;

    localparam logic REG_CAPACITY = 1'b0;

    logic [CFG_W-1:0] r_capacity;
    logic             cfg_wr;

    logic             f_vld;
    t_req             f_req;
    logic             q_full;
    logic             q_vld;
    t_req             q_req;
    logic             q_pop;
    t_rsp             rsp;
    t_stat            stat;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CFG_W'(16);
        end else if (cfg_wr && paddr[2] == REG_CAPACITY) begin
            r_capacity <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(r_capacity) : '0;

    ffac_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_op    (s_axis_tuser),
        .i_addr  (s_axis_tdata[31:0]),
        .i_data  (s_axis_tdata[63:32]),
        .o_valid (f_vld),
        .o_req   (f_req),
        .i_full  (q_full)
    );

    ffac_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_vld),
        .i_req   (f_req),
        .o_full  (q_full),
        .o_valid (q_vld),
        .o_req   (q_req),
        .i_pop   (q_pop)
    );

    ffac_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_capacity (r_capacity),
        .i_valid    (q_vld),
        .i_req      (q_req),
        .o_pop      (q_pop),
        .o_valid    (m_axis_tvalid),
        .o_rsp      (rsp),
        .i_ready    (m_axis_tready),
        .o_stat     (stat)
    );

    // pack the result
    assign m_axis_tdata = {7'd0, rsp.evict_dirty, rsp.evict_data,
                           rsp.evict_addr, rsp.read_data};
    assign m_axis_tuser = {rsp.evicted, rsp.hit};

    // occupancy never exceeds the slot count
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(stat.occupancy) <= ENTRIES)
        else $error("occupancy above entry count");

    // victim pointer stays inside the occupied slots
    a_oldest_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stat.occupancy != '0) |-> (OCC_W'(stat.oldest) < stat.occupancy))
        else $error("oldest slot outside occupied range");

    // an eviction only follows a miss
    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && rsp.evicted) |-> !rsp.hit)
        else $error("eviction reported together with a hit");

    // a queued request reaches an empty output register in the next cycle
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_vld && !m_axis_tvalid) |=> m_axis_tvalid)
        else $error("queued request not taken by idle back end");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ffac_pkg::*;

    localparam logic [2:0] REG_CAPACITY = 3'd0;
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         SETTLE       = 6;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    wire           s_axis_tready;
    logic [63:0]   s_tdata = '0;    // addr[31:0], data[63:32]
    logic [1:0]    s_tuser = '0;    // op[1:0]
    wire           m_axis_tvalid;
    logic          m_tready = 1'b0;
    wire  [103:0]  m_axis_tdata;    // read_data[31:0], evict_addr[63:32],
                                    // evict_data[95:64], evict_dirty[96]
    wire  [1:0]    m_axis_tuser;    // hit[0], evicted[1]
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [2:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    wire  [31:0]   prdata;
    wire           pready;

    fifo_fully_assoc_cache u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // shadow copy of the cache contents
    logic [31:0]  shadow_addr [ENTRIES];
    logic [31:0]  shadow_data [ENTRIES];
    logic         shadow_dirty[ENTRIES];
    int           shadow_occ = 0;
    int           shadow_oldest = 0;
    int           shadow_cap = 16;

    t_rsp         pending_rsp[$];
    logic [31:0]  addr_pool[$];
    int           error_count = 0;
    int           cycle_count = 0;
    bit           steady_send = 1'b0;
    bit           steady_recv = 1'b0;
    int           stall_left = 0;
    t_rsp         want;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // expected result of one access, and update of the shadow cache
    function automatic t_rsp predict_access(input logic [1:0] op_in,
                                            input logic [31:0] addr,
                                            input logic [31:0] data);
        t_rsp       r;
        logic [1:0] op;
        int         slot;
        int         tgt;
        int         eff;
        r    = '0;
        op   = (op_in == OP_UNUSED) ? OP_READ : op_in;
        slot = -1;
        for (int i = 0; i < shadow_occ; i++) begin
            if (slot < 0 && shadow_addr[i] == addr) slot = i;
        end
        r.hit = (slot >= 0);
        if (op == OP_READ) begin
            if (slot >= 0) r.read_data = shadow_data[slot];
        end else if (slot >= 0) begin
            shadow_data[slot]  = data;
            shadow_dirty[slot] = (op == OP_WRITE);
        end else begin
            eff = (shadow_cap == 0) ? 1 : ((shadow_cap > ENTRIES) ? ENTRIES : shadow_cap);
            if (shadow_occ < eff) begin
                tgt = shadow_occ;
                shadow_occ++;
            end else begin
                tgt = (shadow_oldest >= shadow_occ) ? 0 : shadow_oldest;
                r.evicted     = 1'b1;
                r.evict_addr  = shadow_addr[tgt];
                r.evict_data  = shadow_data[tgt];
                r.evict_dirty = shadow_dirty[tgt];
                shadow_oldest = (tgt + 1 >= shadow_occ) ? 0 : tgt + 1;
            end
            shadow_addr[tgt]  = addr;
            shadow_data[tgt]  = data;
            shadow_dirty[tgt] = (op == OP_WRITE);
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_send || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // result checking
    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_tready) begin
            if (pending_rsp.size() == 0) begin
                $error("result with no request outstanding");
                error_count++;
            end else begin
                want = pending_rsp.pop_front();
                check_field("hit",         32'(want.hit),         32'(m_axis_tuser[0]));
                check_field("read_data",   want.read_data,        m_axis_tdata[31:0]);
                check_field("evicted",     32'(want.evicted),     32'(m_axis_tuser[1]));
                check_field("evict_addr",  want.evict_addr,       m_axis_tdata[63:32]);
                check_field("evict_data",  want.evict_data,       m_axis_tdata[95:64]);
                check_field("evict_dirty", 32'(want.evict_dirty), 32'(m_axis_tdata[96]));
            end
        end
    end

    // result-side backpressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!steady_recv && $urandom_range(0, 99) < 25) begin
            stall_left = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 2)
                                                      : $urandom_range(4, 24);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // send one request and record its expected result
    task automatic send_access(input logic [1:0] op, input logic [31:0] addr,
                               input logic [31:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {data, addr};
        s_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_rsp.push_back(predict_access(op, addr, data));
    endtask

    // hold off until every result is back and the pipeline is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [31:0] value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_CAPACITY;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_cap = int'(value[4:0]);
        @(posedge i_clk);
    endtask

    task automatic fill_pool(input int n);
        addr_pool.delete();
        addr_pool.push_back(32'h0000_0000);
        addr_pool.push_back(32'hFFFF_FFFF);
        for (int i = 2; i < n; i++) addr_pool.push_back($urandom);
    endtask

    task automatic random_access();
        int          r;
        logic [1:0]  op;
        logic [31:0] addr;
        logic [31:0] data;
        r = $urandom_range(0, 99);
        if (r < 40)      op = OP_READ;
        else if (r < 65) op = OP_PUT;
        else if (r < 95) op = OP_WRITE;
        else             op = OP_UNUSED;
        if ($urandom_range(0, 99) < 75)
            addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
        else
            addr = $urandom;
        r = $urandom_range(0, 19);
        data = (r == 0) ? 32'h0 : ((r == 1) ? 32'hFFFF_FFFF : $urandom);
        send_access(op, addr, data);
    endtask

    // basic ops, hits and misses at reset capacity
    task automatic test_basic_ops();
        send_access(OP_READ,   32'h0000_0000, 32'hDEAD_BEEF);
        send_access(OP_WRITE,  32'h0000_0000, 32'hFFFF_FFFF);
        send_access(OP_READ,   32'h0000_0000, 32'h0);
        send_access(OP_PUT,    32'hFFFF_FFFF, 32'h0000_0000);
        send_access(OP_READ,   32'hFFFF_FFFF, 32'h1234_5678);
        // put on a hit cleans the entry
        send_access(OP_PUT,    32'h0000_0000, 32'h1234_5678);
        // write on a hit dirties it
        send_access(OP_WRITE,  32'hFFFF_FFFF, 32'hA5A5_A5A5);
        // unused op behaves as read, hit and miss
        send_access(OP_UNUSED, 32'h0000_0000, 32'h5A5A_5A5A);
        send_access(OP_UNUSED, 32'h8000_0001, 32'hFFFF_FFFF);
    endtask

    // capacity lowered below occupancy, zero, and above the entry count
    task automatic test_capacity_edges();
        set_capacity(32'd1);
        send_access(OP_WRITE, 32'h1111_1111, 32'h0000_0001);
        send_access(OP_PUT,   32'h2222_2222, 32'h0000_0002);
        send_access(OP_WRITE, 32'h3333_3333, 32'h0000_0003);
        send_access(OP_READ,  32'h3333_3333, 32'h0);
        set_capacity(32'd0);
        send_access(OP_PUT,   32'h4444_4444, 32'h8000_0000);
        send_access(OP_WRITE, 32'h5555_5555, 32'h7FFF_FFFF);
        set_capacity(32'hFFFF_FFFF);
        send_access(OP_WRITE, 32'h6666_6666, 32'hCAFE_F00D);
        send_access(OP_PUT,   32'h7777_7777, 32'h0BAD_F00D);
        send_access(OP_READ,  32'h5555_5555, 32'h0);
        send_access(OP_READ,  32'h6666_6666, 32'h0);
    endtask

    task automatic test_random_phase(input logic [31:0] cap, input int n,
                                     input bit steady);
        set_capacity(cap);
        fill_pool((cap[4:0] > 0 && cap[4:0] <= ENTRIES) ? int'(cap[4:0]) + 5 : 20);
        steady_send = steady;
        steady_recv = steady;
        for (int i = 0; i < n; i++) random_access();
        steady_send = 1'b0;
        steady_recv = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_ops();
        test_capacity_edges();
        test_random_phase(32'd16, 60, 1'b0);
        test_random_phase(32'd1,  45, 1'b0);
        test_random_phase(32'd5,  55, 1'b1);
        test_random_phase(32'd0,  40, 1'b0);
        test_random_phase(32'd31, 60, 1'b0);
        test_random_phase(32'd8,  55, 1'b0);
        test_random_phase(32'd3,  50, 1'b0);
        test_random_phase(32'd16, 60, 1'b1);
        test_random_phase(32'd2,  45, 1'b0);
        test_random_phase(32'd12, 60, 1'b0);
        test_random_phase(32'd20, 25, 1'b0);
        drain();
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ffac_pkg.sv
rtl/ffac_front.sv
rtl/ffac_queue.sv
rtl/ffac_back.sv
rtl/fifo_fully_assoc_cache.sv
sim/tb_top.sv
